/* rtl/cle_pkg.sv */
`default_nettype none
package cle_pkg;

  localparam int MaxNodesDefault = 64;
  localparam int TickBitsDefault = 16;

  localparam int TermW  = 64;
  localparam int NodeW  = 6;
  localparam int TmoW   = 16;
  localparam int CfgW   = 64;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SELF_ID        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NODE_COUNT     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ELECTION_TMO   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LAST_LOG_TERM  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LAST_LOG_INDEX = 3'd4;

  localparam logic [NodeW-1:0] SELF_ID_RST    = 6'd1;
  localparam logic [NodeW-1:0] NODE_COUNT_RST = 6'd3;
  localparam logic [TmoW-1:0]  TIMEOUT_RST    = 16'd150;

  localparam logic OP_MSG  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] MSG_HEARTBEAT = 3'd0;
  localparam logic [2:0] MSG_HB_RESP   = 3'd1;
  localparam logic [2:0] MSG_APPEND    = 3'd2;
  localparam logic [2:0] MSG_APP_RESP  = 3'd3;
  localparam logic [2:0] MSG_VOTE_REQ  = 3'd4;
  localparam logic [2:0] MSG_VOTE_RESP = 3'd5;
  localparam logic [2:0] MSG_PROPOSAL  = 3'd6;
  localparam logic [2:0] MSG_OTHER     = 3'd7;

  localparam logic [2:0] RSP_NONE         = 3'd0;
  localparam logic [2:0] RSP_INVALID_TERM = 3'd1;
  localparam logic [2:0] RSP_VOTE_REQUEST = 3'd2;
  localparam logic [2:0] RSP_VOTE_RESP    = 3'd3;
  localparam logic [2:0] RSP_HB_RESP      = 3'd4;
  localparam logic [2:0] RSP_APP_RESP     = 3'd5;

  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  typedef struct packed {
    logic             op;
    logic [2:0]       msg_type;
    logic [TermW-1:0] peer_term;
    logic [NodeW-1:0] msg_from;
    logic [TermW-1:0] msg_log_term;
    logic [TermW-1:0] msg_index;
    logic             msg_reject;
  } msg_t;

  typedef struct packed {
    logic [2:0]       rsp_type;
    logic [TermW-1:0] rsp_term;
    logic [NodeW-1:0] rsp_to;
    logic [TermW-1:0] rsp_index;
    logic [TermW-1:0] rsp_log_term;
    logic             rsp_reject;
    logic [1:0]       role_now;
  } rsp_t;

endpackage
`default_nettype wire

/* rtl/cle_chan_if.sv */
`default_nettype none
interface cle_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/consensus_leader_election_node_top.sv */
// Path: a word accepted on msg is registered in the input register, then processed and
// written to the result buffer, from which it is offered on rsp; a full buffer stalls it.
// Throughput: one word per cycle; a two-entry result buffer lets msg run on while rsp
// stalls, until the buffer and the input register are full.
// Reset (rst, synchronous, active high): follower, term 0, no vote, tick count 0,
// vote records clear, registers back to reset values, both buffers empty.
`default_nettype none
module consensus_leader_election_node_top import cle_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDefault,
  parameter int TICK_BITS = TickBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_idx,
  input  wire logic [CfgW-1:0]    wr_data,
  cle_chan_if.sink                msg,
  cle_chan_if.source              rsp
);

  localparam int IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PeerW = (IdxW > NodeW) ? IdxW : NodeW;
  localparam int CntW = $clog2(MAX_NODES + 1);

  logic [NodeW-1:0] self_id;
  logic [NodeW-1:0] node_count;
  logic [TmoW-1:0]  tmo_limit;
  logic [TermW-1:0] last_log_term;
  logic [TermW-1:0] last_log_index;

  logic [1:0]           role, role_next;
  logic [TermW-1:0]     current_term, term_next;
  logic [NodeW-1:0]     voted_for, voted_next;
  logic [TICK_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [MAX_NODES-1:0] seen, seen_next;
  logic [CntW-1:0]      yes_count, yes_next;

  logic s1_valid;
  msg_t s1_data;
  logic step;

  rsp_t       obuf [2];
  logic       wptr, rptr;
  logic [1:0] ocnt;
  logic       push, pop;

  rsp_t             r;
  logic             tmo;
  logic             up_to_date;
  logic [NodeW-1:0] voted_req;
  logic [PeerW-1:0] from_ext, self_ext;
  logic             from_ok, self_ok;
  logic [NodeW-1:0] majority;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id        <= SELF_ID_RST;
      node_count     <= NODE_COUNT_RST;
      tmo_limit      <= TIMEOUT_RST;
      last_log_term  <= '0;
      last_log_index <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_SELF_ID:        self_id        <= wr_data[NodeW-1:0];
        REG_NODE_COUNT:     node_count     <= wr_data[NodeW-1:0];
        REG_ELECTION_TMO:   tmo_limit      <= wr_data[TmoW-1:0];
        REG_LAST_LOG_TERM:  last_log_term  <= wr_data;
        REG_LAST_LOG_INDEX: last_log_index <= wr_data;
        default: ;
      endcase
    end
  end

  assign push = step;
  assign pop  = rsp.valid && rsp.ready;
  assign step = s1_valid && ((ocnt != 2'd2) || pop);
  assign msg.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_data <= msg.data;
    end
  end

  assign from_ext = PeerW'(s1_data.msg_from);
  assign self_ext = PeerW'(self_id);
  assign from_ok  = 32'(s1_data.msg_from) < MAX_NODES;
  assign self_ok  = 32'(self_id) < MAX_NODES;
  assign majority = (node_count >> 1) + NodeW'(1);
  assign elapsed_inc = (elapsed != '1) ? elapsed + TICK_BITS'(1) : elapsed;
  assign up_to_date = (s1_data.msg_log_term > last_log_term) ||
                      ((s1_data.msg_log_term == last_log_term) &&
                       (s1_data.msg_index >= last_log_index));

  always_comb begin
    role_next    = role;
    term_next    = current_term;
    voted_next   = voted_for;
    elapsed_next = elapsed;
    seen_next    = seen;
    yes_next     = yes_count;
    voted_req    = voted_for;
    tmo          = 1'b0;
    r            = '0;

    if (s1_data.op == OP_TICK) begin
      elapsed_next = elapsed_inc;
      tmo = 32'(elapsed_inc) > 32'(tmo_limit);
    end else if (s1_data.peer_term < current_term) begin
      r.rsp_type = RSP_INVALID_TERM;
      r.rsp_to   = s1_data.msg_from;
    end else begin
      if (s1_data.peer_term > current_term) begin
        role_next  = ROLE_FOLLOWER;
        term_next  = s1_data.peer_term;
        voted_next = '0;
      end
      tmo = 32'(elapsed) > 32'(tmo_limit);
      if (!tmo) begin
        if (role_next == ROLE_FOLLOWER) begin
          case (s1_data.msg_type)
            MSG_HEARTBEAT: begin
              r.rsp_type   = RSP_HB_RESP;
              r.rsp_to     = s1_data.msg_from;
              elapsed_next = '0;
            end
            MSG_APPEND: begin
              r.rsp_type   = RSP_APP_RESP;
              r.rsp_to     = s1_data.msg_from;
              elapsed_next = '0;
            end
            MSG_VOTE_REQ: begin
              voted_req = (up_to_date && (voted_next == '0)) ? s1_data.msg_from
                                                              : voted_next;
              voted_next   = voted_req;
              r.rsp_type   = RSP_VOTE_RESP;
              r.rsp_to     = s1_data.msg_from;
              r.rsp_reject = s1_data.msg_from != voted_req;
              elapsed_next = '0;
            end
            default: ;
          endcase
        end else if ((role_next == ROLE_CANDIDATE) && (s1_data.msg_type == MSG_VOTE_RESP)) begin
          if (from_ok && !seen[from_ext[IdxW-1:0]]) begin
            seen_next[from_ext[IdxW-1:0]] = 1'b1;
            if (!s1_data.msg_reject) begin
              yes_next = yes_count + CntW'(1);
            end
          end
          if (32'(yes_next) >= 32'(majority)) begin
            role_next = ROLE_LEADER;
          end
        end
      end
    end

    if (tmo) begin
      elapsed_next = '0;
      if (role_next != ROLE_LEADER) begin
        role_next  = ROLE_CANDIDATE;
        term_next  = (term_next != '1) ? term_next + TermW'(1) : term_next;
        voted_next = self_id;
        seen_next  = '0;
        yes_next   = '0;
        if (self_ok) begin
          seen_next[self_ext[IdxW-1:0]] = 1'b1;
          yes_next = CntW'(1);
        end
        r.rsp_type     = RSP_VOTE_REQUEST;
        r.rsp_index    = last_log_index;
        r.rsp_log_term = last_log_term;
      end
    end

    r.rsp_term = term_next;
    r.role_now = role_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      role         <= ROLE_FOLLOWER;
      current_term <= '0;
      voted_for    <= '0;
      elapsed      <= '0;
      seen         <= '0;
      yes_count    <= '0;
    end else if (step) begin
      role         <= role_next;
      current_term <= term_next;
      voted_for    <= voted_next;
      elapsed      <= elapsed_next;
      seen         <= seen_next;
      yes_count    <= yes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      ocnt <= ocnt + 2'(push) - 2'(pop);
    end
  end

  assign rsp.valid = ocnt != 2'd0;
  assign rsp.data  = obuf[rptr];

  a_term_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> current_term >= $past(current_term))
    else $error("term decreased");

  a_ticks_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(step)) |-> $stable(elapsed))
    else $error("tick count moved without a processed word");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> ocnt != 2'd0)
    else $error("processed word not offered");

  a_leader_from_candidate: assert property (@(posedge clk) disable iff (rst)
    $rose(role == ROLE_LEADER) |-> $past(role) == ROLE_CANDIDATE)
    else $error("leader reached without candidacy");

endmodule
`default_nettype wire
